/* rtl/core/zavc_pkg.sv */
// shared types, codes and constants of the attribute value converter
package zavc_pkg;

    // field widths
    localparam int ID_W      = 16;
    localparam int RAW_W     = 17;
    localparam int VALUE_W   = 48;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // register stages from input to the last pipeline register
    localparam int PIPE_DEPTH = 7;

    // cluster and attribute identifiers
    localparam logic [ID_W-1:0] CL_POWER     = 16'h0001;
    localparam logic [ID_W-1:0] CL_ONOFF     = 16'h0006;
    localparam logic [ID_W-1:0] CL_ILLUM     = 16'h0400;
    localparam logic [ID_W-1:0] CL_TEMP      = 16'h0402;
    localparam logic [ID_W-1:0] CL_PRESS     = 16'h0403;
    localparam logic [ID_W-1:0] CL_HUMID     = 16'h0405;
    localparam logic [ID_W-1:0] CL_SOIL      = 16'h0408;
    localparam logic [ID_W-1:0] AT_MEAS      = 16'h0000;
    localparam logic [ID_W-1:0] AT_BATT_VOLT = 16'h0020;
    localparam logic [ID_W-1:0] AT_BATT_PCT  = 16'h0021;

    // sentinel raw values
    localparam logic signed [RAW_W-1:0] SENT_S16_POS = 17'sd32768;
    localparam logic signed [RAW_W-1:0] SENT_S16_NEG = -17'sd32768;
    localparam logic signed [RAW_W-1:0] SENT_U16     = 17'sd65535;
    localparam logic signed [RAW_W-1:0] SENT_U8      = 17'sd255;

    // conversion kinds
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DIV100    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PRESS     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BATT_PCT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BATT_VOLT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ONOFF     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_POW10     = 3'd6;

    // battery voltage line: raw*20-500, clamped
    localparam int VOLT_OFS = 500;
    localparam int PCT_MAX  = 100;

    // divide by 100: reciprocal for the integer part of |raw|
    localparam int D100      = 100;
    localparam int D100_HALF = 50;
    localparam int D100_K1   = RAW_W + 7;
    localparam int D100_M1_W = 18;
    localparam logic [63:0] D100_M1 = (64'd1 << D100_K1) / 64'd100 + 64'd1;
    localparam int QA_W      = 10;
    localparam int RA_W      = 7;

    // exponent path: log2(10) in Q28 split as 10000*POW_A + POW_B
    localparam int LOG_FRAC   = 28;
    localparam int POW_DIV    = 10000;
    localparam int POW_A      = 891723283 / POW_DIV;
    localparam int POW_B      = 891723283 % POW_DIV;
    localparam int POW_OFF_E  = 15;
    localparam int POW_OFF    = POW_DIV << POW_OFF_E;
    localparam int POW_OFF_Q  = 1 << POW_OFF_E;
    localparam int DIV_K      = 44;
    localparam logic [63:0] DIV_M = (64'd1 << DIV_K) / 64'd10000 + 64'd1;
    localparam int X_W        = RAW_W + 1;
    localparam int XA_W       = 35;
    localparam int NB_W       = 30;
    localparam int Q_W        = 17;
    localparam int E_W        = XA_W - LOG_FRAC;

    // mantissa table in Q30
    localparam int ROM_FRAC  = 30;
    localparam int ROM_W     = 32;
    localparam int POW_TERMS = 14;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic [63:0] ONE_Q30 = 64'd1 << ROM_FRAC;
    localparam logic [ROM_W-1:0] TWO_Q30 = 32'h8000_0000;

    // control that travels beside the data
    typedef struct packed {
        logic              acc;
        logic              val;
        logic [KIND_W-1:0] kind;
    } ctrl_t;

    // one result
    typedef struct packed {
        logic               acc;
        logic               val;
        logic [VALUE_W-1:0] value;
    } res_t;

    // 2^(z/ln2) by a truncated series, z in Q30
    function automatic logic [ROM_W-1:0] pow_entry(input logic [63:0] z);
        logic [63:0] term;
        logic [63:0] sum;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int k = 1; k <= POW_TERMS; k++) begin
            term = ((term * z) >> ROM_FRAC) / 64'(k);
            sum  = sum + term;
        end
        return sum[ROM_W-1:0];
    endfunction

endpackage

/* rtl/core/zavc_decode.sv */
// cluster and attribute decode with sentinel checks
module zavc_decode (
    input  logic [15:0]         cluster_id,
    input  logic [15:0]         attribute_id,
    input  logic signed [16:0]  raw_value,
    output zavc_pkg::ctrl_t     ctrl
);
    import zavc_pkg::*;

    logic s16_sent;
    logic u16_sent;
    logic u8_sent;

    // sentinel compares
    assign s16_sent = (raw_value == SENT_S16_POS) || (raw_value == SENT_S16_NEG);
    assign u16_sent = (raw_value == SENT_U16);
    assign u8_sent  = (raw_value == SENT_U8);

    // report classification
    always_comb begin
        ctrl.acc  = 1'b0;
        ctrl.val  = 1'b0;
        ctrl.kind = KIND_NONE;
        if (cluster_id == CL_POWER) begin
            if (attribute_id == AT_BATT_PCT) begin
                ctrl.acc  = 1'b1;
                ctrl.val  = !u8_sent;
                ctrl.kind = KIND_BATT_PCT;
            end else if (attribute_id == AT_BATT_VOLT) begin
                ctrl.acc  = 1'b1;
                ctrl.val  = !u8_sent;
                ctrl.kind = KIND_BATT_VOLT;
            end
        end else if (attribute_id == AT_MEAS) begin
            unique case (cluster_id) inside
                CL_TEMP: begin
                    ctrl.acc  = 1'b1;
                    ctrl.val  = !s16_sent;
                    ctrl.kind = KIND_DIV100;
                end
                CL_HUMID, CL_SOIL: begin
                    ctrl.acc  = 1'b1;
                    ctrl.val  = !u16_sent;
                    ctrl.kind = KIND_DIV100;
                end
                CL_PRESS: begin
                    ctrl.acc  = 1'b1;
                    ctrl.val  = !s16_sent;
                    ctrl.kind = KIND_PRESS;
                end
                CL_ONOFF: begin
                    ctrl.acc  = 1'b1;
                    ctrl.val  = 1'b1;
                    ctrl.kind = KIND_ONOFF;
                end
                CL_ILLUM: begin
                    ctrl.acc  = 1'b1;
                    ctrl.val  = (raw_value != '0) && !u16_sent;
                    ctrl.kind = KIND_POW10;
                end
                default: begin
                    ctrl.acc  = 1'b0;
                    ctrl.val  = 1'b0;
                    ctrl.kind = KIND_NONE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/zavc_linear.sv */
// linear conversions: rounded divide by 100, scaling, clamp and on/off
module zavc_linear #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [16:0]             raw_value,
    input  logic [zavc_pkg::KIND_W-1:0]    kind,
    output logic [zavc_pkg::VALUE_W-1:0]   value
);
    import zavc_pkg::*;

    // second reciprocal, for the remainder scaled into the fraction
    localparam int N2_W = FRAC_BITS + 7;
    localparam int K2   = N2_W + 7;
    localparam int M2_W = K2 - 6;
    localparam int P2_W = N2_W + M2_W;
    localparam logic [63:0] M2 = (64'd1 << K2) / 64'd100 + 64'd1;
    localparam int DLY  = PIPE_DEPTH - 4;
    localparam int PA_W = RAW_W + D100_M1_W;

    // stage 1
    logic [RAW_W:0]          neg_ext;
    logic [RAW_W-1:0]        mag_a;
    logic signed [VALUE_W-1:0] rv48;
    logic signed [22:0]      r23;
    logic signed [22:0]      p20;
    logic [RA_W-1:0]         pct;
    logic [VALUE_W-1:0]      sv_next;
    logic [PA_W-1:0]         r1_pa_reg;
    logic [RAW_W-1:0]        r1_a_reg;
    logic                    r1_neg_reg;
    logic                    r1_div_reg;
    logic [VALUE_W-1:0]      r1_sv_reg;
    // stage 2
    logic [QA_W-1:0]         qa;
    logic [RAW_W-1:0]        ra_full;
    logic [QA_W-1:0]         r2_qa_reg;
    logic [RA_W-1:0]         r2_ra_reg;
    logic                    r2_neg_reg;
    logic                    r2_div_reg;
    logic [VALUE_W-1:0]      r2_sv_reg;
    // stage 3
    logic [N2_W-1:0]         n2;
    logic [P2_W-1:0]         r3_p2_reg;
    logic [QA_W-1:0]         r3_qa_reg;
    logic                    r3_neg_reg;
    logic                    r3_div_reg;
    logic [VALUE_W-1:0]      r3_sv_reg;
    // stage 4 and delay
    logic [FRAC_BITS-1:0]    q2;
    logic [VALUE_W-1:0]      mag;
    logic [VALUE_W-1:0]      r4_next;
    logic [VALUE_W-1:0]      dly_reg [DLY+1];

    // magnitude, reciprocal product and simple conversions
    assign neg_ext = -{raw_value[RAW_W-1], raw_value};
    assign mag_a   = raw_value[RAW_W-1] ? neg_ext[RAW_W-1:0] : raw_value[RAW_W-1:0];
    assign rv48    = VALUE_W'(raw_value);
    assign r23     = 23'(raw_value);
    assign p20     = (r23 <<< 4) + (r23 <<< 2) - 23'(VOLT_OFS);

    // battery voltage clamp
    always_comb begin
        if (p20 < 0) begin
            pct = '0;
        end else if (p20 > 23'(PCT_MAX)) begin
            pct = RA_W'(PCT_MAX);
        end else begin
            pct = p20[RA_W-1:0];
        end
    end

    // value for the kinds without a divide
    always_comb begin
        case (kind)
            KIND_PRESS:     sv_next = rv48 <<< FRAC_BITS;
            KIND_BATT_PCT:  sv_next = rv48 <<< (FRAC_BITS - 1);
            KIND_BATT_VOLT: sv_next = VALUE_W'(pct) << FRAC_BITS;
            KIND_ONOFF:     sv_next = (raw_value != '0) ? (VALUE_W'(1) << FRAC_BITS) : '0;
            default:        sv_next = '0;
        endcase
    end

    // integer quotient and remainder of |raw| by 100
    assign qa      = r1_pa_reg[D100_K1 +: QA_W];
    assign ra_full = r1_a_reg - RAW_W'(qa) * RAW_W'(D100);

    // remainder in the fraction, rounded half up
    assign n2 = (N2_W'(r2_ra_reg) << FRAC_BITS) + N2_W'(D100_HALF);

    // recombine and apply the sign
    assign q2      = r3_p2_reg[K2 +: FRAC_BITS];
    assign mag     = (VALUE_W'(r3_qa_reg) << FRAC_BITS) + VALUE_W'(q2);
    assign r4_next = r3_div_reg ? (r3_neg_reg ? -mag : mag) : r3_sv_reg;

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (en) begin
            r1_pa_reg  <= PA_W'(mag_a) * PA_W'(D100_M1);
            r1_a_reg   <= mag_a;
            r1_neg_reg <= raw_value[RAW_W-1];
            r1_div_reg <= (kind == KIND_DIV100);
            r1_sv_reg  <= sv_next;
            r2_qa_reg  <= qa;
            r2_ra_reg  <= ra_full[RA_W-1:0];
            r2_neg_reg <= r1_neg_reg;
            r2_div_reg <= r1_div_reg;
            r2_sv_reg  <= r1_sv_reg;
            r3_p2_reg  <= P2_W'(n2) * P2_W'(M2);
            r3_qa_reg  <= r2_qa_reg;
            r3_neg_reg <= r2_neg_reg;
            r3_div_reg <= r2_div_reg;
            r3_sv_reg  <= r2_sv_reg;
            dly_reg[0] <= r4_next;
            for (int i = 1; i <= DLY; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign value = dly_reg[DLY];

endmodule

/* rtl/core/zavc_pow10.sv */
// pipelined 10^((raw-1)/10000) by base-2 split, table and interpolation
module zavc_pow10 #(
    parameter int FRAC_BITS       = 16,
    parameter int POW_TABLE_DEPTH = 256
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [16:0]             raw_value,
    output logic [zavc_pkg::VALUE_W-1:0]   value
);
    import zavc_pkg::*;

    localparam int IDX_W = $clog2(POW_TABLE_DEPTH);
    localparam int DEP_W = $clog2(POW_TABLE_DEPTH + 1);
    localparam int POS_W = LOG_FRAC + DEP_W;
    localparam int QP_W  = DIV_K + Q_W;
    localparam int DP_W  = ROM_W + LOG_FRAC;
    localparam int V_W   = ROM_W + 1;
    localparam logic signed [7:0] S_BIAS = 8'(FRAC_BITS - ROM_FRAC);

    logic [ROM_W-1:0]          lo_rom [POW_TABLE_DEPTH];
    logic [ROM_W-1:0]          hi_rom [POW_TABLE_DEPTH];
    // stage 1
    logic signed [X_W-1:0]     x;
    logic signed [XA_W-1:0]    xa_next;
    logic signed [30:0]        nb_next;
    logic signed [XA_W-1:0]    r1_xa_reg;
    logic [NB_W-1:0]           r1_nb_reg;
    // stage 2
    logic [QP_W-1:0]           qp;
    logic signed [XA_W-1:0]    r2_xa_reg;
    logic [Q_W-1:0]            r2_q_reg;
    // stage 3
    logic [XA_W-1:0]           y;
    logic [POS_W-1:0]          pos;
    logic [E_W-1:0]            r3_e_reg;
    logic [IDX_W-1:0]          r3_idx_reg;
    logic [LOG_FRAC-1:0]       r3_rem_reg;
    // stage 4
    logic [ROM_W-1:0]          lo;
    logic [ROM_W-1:0]          hi;
    logic [E_W-1:0]            r4_e_reg;
    logic [ROM_W-1:0]          r4_lo_reg;
    logic [ROM_W-1:0]          r4_diff_reg;
    logic [LOG_FRAC-1:0]       r4_rem_reg;
    // stage 5
    logic [DP_W-1:0]           dp;
    logic [E_W-1:0]            r5_e_reg;
    logic [ROM_W-1:0]          r5_lo_reg;
    logic [ROM_W-1:0]          r5_add_reg;
    // stage 6
    logic [V_W-1:0]            r6_v_reg;
    logic signed [7:0]         r6_s_reg;
    // stage 7
    logic signed [7:0]         neg_s;
    logic [5:0]                rs;
    logic [V_W:0]              rnd;
    logic [V_W:0]              rsh;
    logic [VALUE_W-1:0]        scaled;
    logic [VALUE_W-1:0]        r7_val_reg;

    // mantissa table, entry i and entry i+1 side by side
    for (genvar i = 0; i < POW_TABLE_DEPTH; i++) begin : g_rom
        localparam logic [63:0] ZL = (64'(i) * LN2_Q30) / 64'(POW_TABLE_DEPTH);
        localparam logic [63:0] ZH = (64'(i + 1) * LN2_Q30) / 64'(POW_TABLE_DEPTH);
        assign lo_rom[i] = pow_entry(ZL);
        if (i == POW_TABLE_DEPTH - 1) begin : g_top
            assign hi_rom[i] = TWO_Q30;
        end else begin : g_mid
            assign hi_rom[i] = pow_entry(ZH);
        end
    end

    // x*A and the offset x*B term
    assign x       = X_W'(raw_value) - X_W'(1);
    assign xa_next = XA_W'(x) * XA_W'(POW_A);
    assign nb_next = 31'(x) * 31'(POW_B) + 31'(POW_OFF);

    // floor(x*B/10000) by reciprocal
    assign qp = QP_W'(r1_nb_reg) * QP_W'(DIV_M);

    // y in Q28, split into exponent and table position
    assign y   = r2_xa_reg + XA_W'(r2_q_reg) - XA_W'(POW_OFF_Q);
    assign pos = POS_W'(y[LOG_FRAC-1:0]) * POS_W'(POW_TABLE_DEPTH);

    // neighbouring entries
    assign lo = lo_rom[r3_idx_reg];
    assign hi = hi_rom[r3_idx_reg];

    // interpolation product
    assign dp = DP_W'(r4_diff_reg) * DP_W'(r4_rem_reg);

    // scaling by 2^s, rounding half up on a right shift
    assign neg_s = -r6_s_reg;
    assign rs    = neg_s[5:0];
    assign rnd   = (V_W + 1)'(r6_v_reg) + ((V_W + 1)'(1) << (rs - 6'd1));
    assign rsh   = rnd >> rs;

    always_comb begin
        if (!r6_s_reg[7]) begin
            scaled = VALUE_W'(r6_v_reg) << r6_s_reg[5:0];
        end else begin
            scaled = VALUE_W'(rsh);
        end
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (en) begin
            r1_xa_reg   <= xa_next;
            r1_nb_reg   <= nb_next[NB_W-1:0];
            r2_xa_reg   <= r1_xa_reg;
            r2_q_reg    <= qp[DIV_K +: Q_W];
            r3_e_reg    <= y[XA_W-1:LOG_FRAC];
            r3_idx_reg  <= pos[LOG_FRAC +: IDX_W];
            r3_rem_reg  <= pos[LOG_FRAC-1:0];
            r4_e_reg    <= r3_e_reg;
            r4_lo_reg   <= lo;
            r4_diff_reg <= (hi > lo) ? (hi - lo) : '0;
            r4_rem_reg  <= r3_rem_reg;
            r5_e_reg    <= r4_e_reg;
            r5_lo_reg   <= r4_lo_reg;
            r5_add_reg  <= dp[LOG_FRAC +: ROM_W];
            r6_v_reg    <= V_W'(r5_lo_reg) + V_W'(r5_add_reg);
            r6_s_reg    <= 8'(signed'(r5_e_reg)) + S_BIAS;
            r7_val_reg  <= scaled;
        end
    end

    assign value = r7_val_reg;

endmodule

/* rtl/core/zavc_out_buf.sv */
// output register with skid stage, decouples ready from the pipeline
module zavc_out_buf (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  zavc_pkg::res_t                    in_res,
    output logic                              pipe_en,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [zavc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic [zavc_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    import zavc_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_res_reg;
    res_t out_res_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_res_reg;
    res_t skid_res_next;
    logic out_free;

    assign pipe_en  = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    // refill from skid first, else take the pipeline result
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end else if (out_free) begin
            out_valid_next = in_valid;
            out_res_next   = in_res;
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.value;
    assign m_axis_tuser  = {out_res_reg.val, out_res_reg.acc};

endmodule

/* rtl/core/zcl_attribute_value_converter_unit.sv */
// Top level of the attribute value converter. Each request carries a
// cluster id, an attribute id and a raw value, and yields one result with an
// accepted flag, a valid flag and a signed value with FRAC_BITS fraction bits.
// The block takes one request per clock while s_axis_tready is high and
// returns one result per clock while m_axis_tready is high; a request
// passes seven pipeline stages set by the illuminance path (reciprocal
// divide by 10000, table lookup, interpolation multiply and the final
// scaling shift) and then the output register. A skid stage behind the output
// register keeps s_axis_tready registered; it drops only while a stalled
// result and a second one are both held. There is no table fill after reset.
module zcl_attribute_value_converter_unit #(
    parameter int FRAC_BITS       = 16,
    parameter int POW_TABLE_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // cluster_id [15:0], attribute_id [31:16], raw_value [48:32], zero pad
    input  logic [zavc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // converted_value [47:0]
    output logic [zavc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // attribute_accepted [0], value_valid [1]
    output logic [zavc_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);
    import zavc_pkg::*;

    logic [ID_W-1:0]          cluster_id;
    logic [ID_W-1:0]          attribute_id;
    logic signed [RAW_W-1:0]  raw_value;
    ctrl_t                    dec_ctrl;
    logic                     pipe_en;
    logic                     pipe_valid_reg [PIPE_DEPTH];
    ctrl_t                    pipe_ctrl_reg  [PIPE_DEPTH];
    logic [VALUE_W-1:0]       lin_value;
    logic [VALUE_W-1:0]       pow_value;
    ctrl_t                    last_ctrl;
    res_t                     res;

    // request fields
    assign cluster_id   = s_axis_tdata[15:0];
    assign attribute_id = s_axis_tdata[31:16];
    assign raw_value    = signed'(s_axis_tdata[48:32]);

    assign s_axis_tready = pipe_en;

    zavc_decode u_decode (
        .cluster_id   (cluster_id),
        .attribute_id (attribute_id),
        .raw_value    (raw_value),
        .ctrl         (dec_ctrl)
    );

    zavc_linear #(
        .FRAC_BITS (FRAC_BITS)
    ) u_linear (
        .aclk      (aclk),
        .en        (pipe_en),
        .raw_value (raw_value),
        .kind      (dec_ctrl.kind),
        .value     (lin_value)
    );

    zavc_pow10 #(
        .FRAC_BITS       (FRAC_BITS),
        .POW_TABLE_DEPTH (POW_TABLE_DEPTH)
    ) u_pow10 (
        .aclk      (aclk),
        .en        (pipe_en),
        .raw_value (raw_value),
        .value     (pow_value)
    );

    // valid bits beside the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                pipe_valid_reg[i] <= 1'b0;
            end
        end else if (pipe_en) begin
            pipe_valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                pipe_valid_reg[i] <= pipe_valid_reg[i-1];
            end
        end
    end

    // decoded control beside the datapath
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pipe_ctrl_reg[0] <= dec_ctrl;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                pipe_ctrl_reg[i] <= pipe_ctrl_reg[i-1];
            end
        end
    end

    // result select, zero when not a measurement
    assign last_ctrl = pipe_ctrl_reg[PIPE_DEPTH-1];
    always_comb begin
        res.acc = last_ctrl.acc;
        res.val = last_ctrl.val;
        if (!last_ctrl.val) begin
            res.value = '0;
        end else if (last_ctrl.kind == KIND_POW10) begin
            res.value = pow_value;
        end else begin
            res.value = lin_value;
        end
    end

    zavc_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (pipe_valid_reg[PIPE_DEPTH-1]),
        .in_res        (res),
        .pipe_en       (pipe_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* rtl/core/zavc_checker.sv */
// port-level checks of the converter, bound to the top level
module zavc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser
);

    // no result straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a value that is no measurement reads as zero
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata == 48'd0)
        else $error("nonzero value with valid flag low");

    // only an accepted report can carry a valid value
    a_valid_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("valid value on a report that was not accepted");

    // input is held off only while a result is waiting
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind zcl_attribute_value_converter_unit zavc_checker u_zavc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
